// ===== rtl/core/rhythm_grid_quantize_swing_defines.svh =====
// Assertion macros for the rhythm grid quantizer.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef RHYTHM_GRID_QUANTIZE_SWING_DEFINES_SVH
`define RHYTHM_GRID_QUANTIZE_SWING_DEFINES_SVH

// Same-cycle implication under reset.
`define RGQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgqs: same-cycle check failed");

// Next-cycle implication under reset.
`define RGQS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgqs: next-cycle check failed");

`endif

// ===== rtl/core/rgqs_pkg.sv =====
// Shared types and constants of the rhythm grid quantizer.
// No dependencies.
package rgqs_pkg;

    localparam int SUB_W = 7;

    typedef enum logic [1:0] {
        REG_SUBDIV   = 2'd0,
        REG_STRENGTH = 2'd1,
        REG_SWING_EN = 2'd2,
        REG_SWING    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic valid;
    } t_stage_ctl;

endpackage

// ===== rtl/core/rgqs_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per cycle while i_en is high.
// Depends on rgqs_pkg.
module rgqs_div_cell import rgqs_pkg::*; #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 7,
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_stage_ctl       i_ctl,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output t_stage_ctl       o_ctl,
    output logic [DEN_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_num,
    output logic [DEN_W-1:0] o_den,
    output logic [PAY_W-1:0] o_pay
);

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_num;
    t_stage_ctl       r_ctl;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [PAY_W-1:0] r_pay;

    // Shift the next numerator bit into the remainder, subtract if it fits.
    always_comb begin
        trial = {i_rem, i_num[NUM_W-1]};
        diff  = trial - {1'b0, i_den};
        ge    = trial >= {1'b0, i_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_num = {i_num[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_pay = r_pay;

endmodule

// ===== rtl/core/rhythm_grid_quantize_swing.sv =====
// Top level of the rhythm grid quantizer with swing.
// Depends on rgqs_pkg, rgqs_div_cell and rhythm_grid_quantize_swing_defines.svh.
//
// Usage:
//   Input channel: i_valid / o_stall carry one note event per beat
//   (note position, beat length, bar origin). Output channel: o_valid /
//   i_stall carry one result per event (snapped, swung, grid_empty).
//   Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
//   (subdivisions, strength, swing enable, swing amount); pready is tied high.
//   Throughput: one event per cycle unless the output is stalled. Two rows
//   of division cells do the arithmetic: BEAT_WIDTH cells form the grid
//   interval, POS_WIDTH cells divide the bar offset by it, one quotient
//   bit per cell.
//   Reset: synchronous, active low; clears all beat valid flags and loads
//   the register defaults. No clearing pass is needed.
//   Stall: the whole pipeline freezes while a finished result waits
//   under i_stall; o_stall is raised only then, so events keep entering
//   while the output is taken.
module rhythm_grid_quantize_swing import rgqs_pkg::*; #(
    parameter int POS_WIDTH  = 48,
    parameter int BEAT_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [POS_WIDTH-1:0]  i_note_position,
    input  logic [BEAT_WIDTH-1:0] i_beat_length,
    input  logic [POS_WIDTH-1:0]  i_bar_origin,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [POS_WIDTH-1:0]  o_snapped_position,
    output logic [POS_WIDTH-1:0]  o_swung_position,
    output logic                  o_grid_empty,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

`include "rhythm_grid_quantize_swing_defines.svh"

    localparam int W  = POS_WIDTH;
    localparam int BW = BEAT_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int LO = W / 2;
    localparam int HI = W - LO;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    // ---------------- configuration registers ----------------
    logic [SUB_W-1:0] r_subdiv;
    logic [F:0]       r_strength;
    logic             r_swing_en;
    logic [F-1:0]     r_swing;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv   <= SUB_W'(4);
            r_strength <= ONE_Q;
            r_swing_en <= 1'b0;
            r_swing    <= {1'b1, {(F-1){1'b0}}};
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_SUBDIV:   r_subdiv   <= pwdata[SUB_W-1:0];
                REG_STRENGTH: r_strength <= pwdata[F:0];
                REG_SWING_EN: r_swing_en <= pwdata[0];
                REG_SWING:    r_swing    <= pwdata[F-1:0];
                default:      r_subdiv   <= r_subdiv;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SUBDIV:   prdata = 32'(r_subdiv);
            REG_STRENGTH: prdata = 32'(r_strength);
            REG_SWING_EN: prdata = 32'(r_swing_en);
            REG_SWING:    prdata = 32'(r_swing);
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Freeze every stage while the output beat is held.
    logic r_out_valid;
    logic en;

    assign o_stall = r_out_valid & i_stall;
    assign en      = ~o_stall;

    // ---------------- entry stage: bar offset ----------------
    typedef struct packed {
        logic [W-1:0] note;
        logic [W-1:0] bar;
        logic [W-1:0] off;
    } t_p1;

    t_stage_ctl    r_s0_ctl;
    t_p1           r_s0_pay;
    logic [BW-1:0] r_s0_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (en) begin
            r_s0_ctl.valid <= i_valid;
        end
        if (en) begin
            r_s0_pay.note <= i_note_position;
            r_s0_pay.bar  <= i_bar_origin;
            r_s0_pay.off  <= i_note_position - i_bar_origin;
            r_s0_beat     <= i_beat_length;
        end
    end

    // ---------------- row 1: grid = beat / subdivisions ----------------
    t_stage_ctl       c1_ctl [0:BW];
    logic [SUB_W-1:0] c1_rem [0:BW];
    logic [BW-1:0]    c1_num [0:BW];
    logic [SUB_W-1:0] c1_den [0:BW];
    logic [$bits(t_p1)-1:0] c1_pay [0:BW];

    assign c1_ctl[0] = r_s0_ctl;
    assign c1_rem[0] = '0;
    assign c1_num[0] = r_s0_beat;
    assign c1_den[0] = r_subdiv;
    assign c1_pay[0] = r_s0_pay;

    for (genvar k = 0; k < BW; k++) begin : g_row1
        rgqs_div_cell #(.NUM_W(BW), .DEN_W(SUB_W), .PAY_W($bits(t_p1))) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (c1_ctl[k]),
            .i_rem  (c1_rem[k]),
            .i_num  (c1_num[k]),
            .i_den  (c1_den[k]),
            .i_pay  (c1_pay[k]),
            .o_ctl  (c1_ctl[k+1]),
            .o_rem  (c1_rem[k+1]),
            .o_num  (c1_num[k+1]),
            .o_den  (c1_den[k+1]),
            .o_pay  (c1_pay[k+1])
        );
    end

    // ---------------- grid stage: half grid, offset magnitude ----------------
    typedef struct packed {
        logic [W-1:0]  note;
        logic [W-1:0]  bar;
        logic          rneg;
        logic [BW-1:0] half;
        logic          empty;
    } t_p2;

    t_p1           p1_out;
    t_stage_ctl    r_g_ctl;
    t_p2           r_g_pay;
    logic [BW-1:0] r_g_grid;
    logic [W-1:0]  r_g_rmag;

    assign p1_out = c1_pay[BW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_ctl <= '0;
        end else if (en) begin
            r_g_ctl <= c1_ctl[BW];
        end
        if (en) begin
            r_g_grid      <= c1_num[BW];
            r_g_pay.note  <= p1_out.note;
            r_g_pay.bar   <= p1_out.bar;
            r_g_pay.rneg  <= p1_out.off[W-1];
            r_g_pay.half  <= c1_num[BW] >> 1;
            r_g_pay.empty <= (r_subdiv == '0) || (c1_num[BW] == '0);
            r_g_rmag      <= p1_out.off[W-1] ? (W'(0) - p1_out.off) : p1_out.off;
        end
    end

    // ---------------- row 2: offset magnitude / grid ----------------
    t_stage_ctl    c2_ctl [0:W];
    logic [BW-1:0] c2_rem [0:W];
    logic [W-1:0]  c2_num [0:W];
    logic [BW-1:0] c2_den [0:W];
    logic [$bits(t_p2)+W-1:0] c2_pay [0:W];

    assign c2_ctl[0] = r_g_ctl;
    assign c2_rem[0] = '0;
    assign c2_num[0] = r_g_rmag;
    assign c2_den[0] = r_g_grid;
    assign c2_pay[0] = {r_g_pay, r_g_rmag};

    for (genvar k = 0; k < W; k++) begin : g_row2
        rgqs_div_cell #(.NUM_W(W), .DEN_W(BW), .PAY_W($bits(t_p2) + W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (c2_ctl[k]),
            .i_rem  (c2_rem[k]),
            .i_num  (c2_num[k]),
            .i_den  (c2_den[k]),
            .i_pay  (c2_pay[k]),
            .o_ctl  (c2_ctl[k+1]),
            .o_rem  (c2_rem[k+1]),
            .o_num  (c2_num[k+1]),
            .o_den  (c2_den[k+1]),
            .o_pay  (c2_pay[k+1])
        );
    end

    // ---------------- tail stages ----------------
    typedef struct packed {
        logic [W-1:0]      note;
        logic              empty;
        logic              swing_on;
        logic              nneg;
        logic [W-1:0]      gp;
        logic [W-1:0]      bar;
        logic [W-1:0]      d;
        logic              dneg;
        logic [W-1:0]      dmag;
        logic              sw_late;
        logic [BW-1:0]     sdelay;
        logic [LO+F:0]     pl;
        logic [HI+F:0]     ph;
        logic [W-1:0]      move;
    } t_tail;

    t_p2           p2_out;
    logic [W-1:0]  rmag2;
    logic [W-1:0]  q2;
    logic [BW-1:0] rem2;
    logic [BW-1:0] grid2;
    logic [BW:0]   up_sum;
    logic [W-1:0]  base_gp;
    logic [F:0]    twice;
    logic [F:0]    sdiff;
    logic [F:0]    s_clamp;
    logic [BW+F:0] sprod;
    logic [W+F:0]  msum;
    t_tail         n1, n2, n3, n4, n5;
    t_stage_ctl    r_t_ctl [0:4];
    t_tail         r_t [0:4];

    assign {p2_out, rmag2} = c2_pay[W];
    assign q2    = c2_num[W];
    assign rem2  = c2_rem[W];
    assign grid2 = c2_den[W];

    // Nearest grid point from quotient and remainder; odd slot for swing.
    always_comb begin
        n1          = '0;
        n1.note     = p2_out.note;
        n1.bar      = p2_out.bar;
        n1.empty    = p2_out.empty;
        up_sum      = {1'b0, rem2} + {1'b0, p2_out.half};
        base_gp     = rmag2 - W'(rem2);
        twice       = {r_swing, 1'b0};
        n1.sw_late  = twice >= ONE_Q;
        sdiff       = n1.sw_late ? (twice - ONE_Q) : (ONE_Q - twice);
        sprod       = (BW+F+1)'(p2_out.half) * (BW+F+1)'(sdiff);
        n1.sdelay   = sprod[BW+F-1:F];
        n1.swing_on = r_swing_en && (r_swing != '0) && !p2_out.rneg && q2[0];
        if (!p2_out.rneg) begin
            n1.nneg = 1'b0;
            n1.gp   = base_gp + ((up_sum >= {1'b0, grid2}) ? W'(grid2) : W'(0));
        end else if (rmag2 > W'(p2_out.half)) begin
            n1.nneg = 1'b1;
            n1.gp   = base_gp - ((rem2 < p2_out.half) ? W'(grid2) : W'(0));
        end else begin
            n1.nneg = 1'b0;
            n1.gp   = '0;
        end
    end

    // Distance from the note to the grid point.
    always_comb begin
        n2   = r_t[0];
        n2.d = r_t[0].bar + (r_t[0].nneg ? (W'(0) - r_t[0].gp) : r_t[0].gp) - r_t[0].note;
    end

    // Split distance into sign and magnitude.
    always_comb begin
        n3      = r_t[1];
        n3.dneg = r_t[1].d[W-1];
        n3.dmag = r_t[1].d[W-1] ? (W'(0) - r_t[1].d) : r_t[1].d;
    end

    // Partial products of magnitude times clamped strength.
    always_comb begin
        n4      = r_t[2];
        s_clamp = (r_strength > ONE_Q) ? ONE_Q : r_strength;
        n4.pl   = (LO+F+1)'(r_t[2].dmag[LO-1:0]) * (LO+F+1)'(s_clamp);
        n4.ph   = (HI+F+1)'(r_t[2].dmag[W-1:LO]) * (HI+F+1)'(s_clamp);
    end

    // Combine partial products and drop the fraction.
    always_comb begin
        n5      = r_t[3];
        msum    = ((W+F+1)'(r_t[3].ph) << LO) + (W+F+1)'(r_t[3].pl);
        n5.move = W'(msum >> F);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_t_ctl[i] <= '0;
            end
        end else if (en) begin
            r_t_ctl[0] <= c2_ctl[W];
            for (int i = 1; i < 5; i++) begin
                r_t_ctl[i] <= r_t_ctl[i-1];
            end
        end
        if (en) begin
            r_t[0] <= n1;
            r_t[1] <= n2;
            r_t[2] <= n3;
            r_t[3] <= n4;
            r_t[4] <= n5;
        end
    end

    // ---------------- output register ----------------
    logic [W-1:0] r_snapped;
    logic [W-1:0] r_swung;
    logic         r_empty;
    logic [W-1:0] sdelay_w;

    assign sdelay_w = W'(r_t[4].sdelay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_t_ctl[4].valid;
        end
        if (en) begin
            r_empty <= r_t[4].empty;
            if (r_t[4].empty) begin
                r_snapped <= r_t[4].note;
                r_swung   <= r_t[4].note;
            end else begin
                r_snapped <= r_t[4].dneg ? (r_t[4].note - r_t[4].move)
                                         : (r_t[4].note + r_t[4].move);
                if (!r_t[4].swing_on) begin
                    r_swung <= r_t[4].note;
                end else if (r_t[4].sw_late) begin
                    r_swung <= r_t[4].note + sdelay_w;
                end else begin
                    r_swung <= r_t[4].note - sdelay_w;
                end
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_snapped_position = r_snapped;
    assign o_swung_position   = r_swung;
    assign o_grid_empty       = r_empty;

    // ---------------- assertions ----------------
    `RGQS_ASSERT_IMP(a_empty_passthrough, r_out_valid && r_empty, r_snapped == r_swung)
    `RGQS_ASSERT_IMP(a_stall_only_on_held, o_stall, r_out_valid)
    `RGQS_ASSERT_NXT(a_held_beat_kept, o_stall, r_out_valid && $stable(r_swung))

endmodule

// ===== sim/tb_rhythm_grid_quantize_swing.sv =====
// Testbench for the rhythm grid quantizer with swing: drives note events,
// predicts snapped and swung positions, and checks every result beat.
// Depends on rgqs_pkg and the rhythm_grid_quantize_swing top level.
`timescale 1ns / 1ps

module tb_rhythm_grid_quantize_swing;
    import rgqs_pkg::*;

    localparam int POS_W  = 48;
    localparam int BEAT_W = 24;
    localparam int FRAC   = 16;
    localparam logic [63:0] POS_MASK = (64'd1 << POS_W) - 1;
    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC;
    localparam int LATENCY  = 8 + BEAT_W + POS_W;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic [POS_W-1:0] snapped;
        logic [POS_W-1:0] swung;
        logic             empty;
    } t_note_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [POS_W-1:0]     i_note_position;
    logic [BEAT_W-1:0]    i_beat_length;
    logic [POS_W-1:0]     i_bar_origin;
    logic                 o_valid;
    logic                 i_stall;
    logic [POS_W-1:0]     o_snapped_position;
    logic [POS_W-1:0]     o_swung_position;
    logic                 o_grid_empty;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow copy of the register file
    logic [6:0]  cfg_subdiv;
    logic [16:0] cfg_strength;
    logic        cfg_swing_en;
    logic [15:0] cfg_swing;

    t_note_result pending_results[$];
    int  mismatch_count;
    int  idle_cycles;
    bit  calm_mode;     // no random idling in the closing part
    int  hold_off;      // long receiver hold-off, counted by its own process

    rhythm_grid_quantize_swing u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Split a POS_W-bit two's complement value into sign and magnitude.
    function automatic logic [63:0] magnitude_of(input logic [63:0] v, output bit neg);
        v &= POS_MASK;
        neg = v[POS_W-1];
        return neg ? ((64'd0 - v) & POS_MASK) : v;
    endfunction

    function automatic t_note_result quantize_note(input logic [63:0] note,
                                                   input logic [63:0] beat,
                                                   input logic [63:0] bar);
        t_note_result r;
        logic [63:0] grid, half, rmag, nmag, gp, nearest, dmag, s, move, twice, delay;
        bit rneg, nneg, dneg;
        grid = (cfg_subdiv == 0) ? 64'd0 : beat / cfg_subdiv;
        if (grid == 0) begin
            r.snapped = note[POS_W-1:0];
            r.swung   = note[POS_W-1:0];
            r.empty   = 1'b1;
            return r;
        end
        half = grid / 2;
        rmag = magnitude_of(note - bar, rneg);
        // Round half up toward the nearest grid point, truncating toward zero
        if (!rneg) begin
            nneg = 0; nmag = rmag + half;
        end else if (rmag > half) begin
            nneg = 1; nmag = rmag - half;
        end else begin
            nneg = 0; nmag = half - rmag;
        end
        gp = (nmag / grid) * grid;
        nearest = (bar + (nneg ? 64'd0 - gp : gp)) & POS_MASK;
        dmag = magnitude_of(nearest - note, dneg);
        s = (cfg_strength > ONE_Q) ? ONE_Q : 64'(cfg_strength);
        move = (dmag * s) >> FRAC;
        r.snapped = 48'((note + (dneg ? 64'd0 - move : move)) & POS_MASK);
        r.swung = note[POS_W-1:0];
        // Delay odd positive slots; below straight swing pulls them earlier
        if (cfg_swing_en && cfg_swing != 0 && !rneg && (((rmag / grid) & 1) != 0)) begin
            twice = 64'(cfg_swing) * 2;
            if (twice >= ONE_Q) begin
                delay = (half * (twice - ONE_Q)) >> FRAC;
                r.swung = 48'((note + delay) & POS_MASK);
            end else begin
                delay = (half * (ONE_Q - twice)) >> FRAC;
                r.swung = 48'((note - delay) & POS_MASK);
            end
        end
        r.empty = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Write one register via the setup and access phases.
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SUBDIV:   cfg_subdiv   = value[6:0];
            REG_STRENGTH: cfg_strength = value[16:0];
            REG_SWING_EN: cfg_swing_en = value[0];
            REG_SWING:    cfg_swing    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int sub, input int str, input int sen, input int sw);
        write_register(REG_SUBDIV, sub);
        write_register(REG_STRENGTH, str);
        write_register(REG_SWING_EN, sen);
        write_register(REG_SWING, sw);
    endtask

    // Drop valid, hold until all results arrived, then let the pipe settle.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one note beat and wait for its acceptance; predict at acceptance.
    task automatic send_note(input logic [63:0] note, input logic [63:0] beat,
                             input logic [63:0] bar);
        int gap;
        if (!calm_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_note_position <= note[POS_W-1:0];
        i_beat_length <= beat[BEAT_W-1:0];
        i_bar_origin <= bar[POS_W-1:0];
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(quantize_note(note & POS_MASK, beat & 24'hFFFFFF,
                                                bar & POS_MASK));
    endtask

    function automatic logic [63:0] rand48();
        return {$urandom(), $urandom()} & POS_MASK;
    endfunction

    // Pick a note close to a grid point of some bar so rounding is exercised.
    task automatic send_musical_note();
        logic [63:0] bar, beat, grid, note;
        int slot;
        bar  = ($urandom_range(0, 3) == 0) ? rand48() : 64'($urandom());
        beat = ($urandom_range(0, 7) == 0) ? 64'($urandom()) & 24'hFFFFFF
                                           : 64'($urandom_range(1, 50000));
        grid = (cfg_subdiv == 0) ? 1 : beat / cfg_subdiv + 1;
        slot = $signed($urandom_range(0, 80)) - 8;
        note = bar + 64'(slot) * grid + 64'($signed($urandom_range(0, 2 * grid))) - grid / 2;
        send_note(note, beat, bar);
    endtask

    task automatic test_directed_edges();
        configure(4, 65536, 1, 49152);
        send_note(0, 0, 0);                           // zero grid
        send_note(POS_MASK, 24'hFFFFFF, 0);           // wrap, negative offset
        send_note(0, 24'hFFFFFF, POS_MASK);
        send_note(1000, 400, 1000);                   // on grid
        send_note(1050, 400, 1000);                   // exact half up
        send_note(1150, 400, 1000);                   // odd slot swung
        send_note(950, 400, 1000);                    // negative rounding
        send_note(940, 400, 1000);
        send_note(3, 3, 0);                           // grid below one
        send_note(POS_MASK, 24'hFFFFFF, POS_MASK);
        send_note(48'hAAAA_AAAA_AAAA, 24'h555555, 48'h5555_5555_5555);
        send_note(48'h5555_5555_5555, 24'hAAAAAA, 48'hAAAA_AAAA_AAAA);
        drain_pipe();
        configure(0, 0, 1, 0);                        // zero divisor, swing amount zero
        send_note(12345, 400, 0);
        send_note(150, 400, 0);
        drain_pipe();
        configure(1, 131071, 1, 1);                   // excess strength, swing below straight
        send_note(150, 100, 0);
        send_note(777, 100, 500);
        drain_pipe();
        configure(64, 32768, 1, 65535);
        send_note(7000, 6400, 0);
        send_note(150000, 6400, 0);
        drain_pipe();
    endtask

    task automatic test_random_settings();
        int sub_opts[] = '{1, 2, 3, 4, 64, 127, 0};
        int str_opts[] = '{0, 1, 32768, 65535, 65536, 131071};
        for (int ph = 0; ph < 6; ph++) begin
            configure(sub_opts[$urandom_range(0, 6)], str_opts[$urandom_range(0, 5)],
                      $urandom_range(0, 1) | (ph < 4), ph == 0 ? 65535 : $urandom_range(0, 65535));
            repeat (50) begin
                if ($urandom_range(0, 9) == 0) send_note(rand48(), $urandom(), rand48());
                else send_musical_note();
            end
            drain_pipe();
        end
    endtask

    // Receiver holds off for a long stretch so the block fills and stalls its input.
    task automatic test_backpressure();
        configure(3, 40000, 1, 20000);
        hold_off = 400;
        repeat (100) send_musical_note();
        drain_pipe();
    endtask

    task automatic test_full_rate();
        calm_mode = 1'b1;
        configure(8, 65536, 1, 32768);
        repeat (50) send_musical_note();
        drain_pipe();
    endtask

    // Result checker against the oldest prediction
    always @(posedge i_clk) begin
        t_note_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_snapped_position, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_snapped_position !== want.snapped)
                    report_mismatch("snapped_position", o_snapped_position, want.snapped);
                if (o_swung_position !== want.swung)
                    report_mismatch("swung_position", o_swung_position, want.swung);
                if (o_grid_empty !== want.empty)
                    report_mismatch("grid_empty", o_grid_empty, want.empty);
            end
        end
    end

    // Receiver stall: random bursts, or a long counted hold-off
    always @(posedge i_clk) begin
        int burst;
        if (!i_rst_n) begin
            i_stall <= 1'b0; burst = 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (burst > 0) begin
            burst--;
            i_stall <= (burst != 0);
        end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no accepted beat and no register access
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_note_position = '0; i_beat_length = '0;
        i_bar_origin = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; mismatch_count = 0; idle_cycles = 0;
        calm_mode = 1'b0; hold_off = 0;
        cfg_subdiv = 4; cfg_strength = 65536; cfg_swing_en = 0; cfg_swing = 32768;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_note(1234, 1000, 0);                     // reset defaults
        drain_pipe();
        test_directed_edges();
        test_random_settings();
        test_backpressure();
        test_full_rate();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
